// File: rtl/core/rua_pkg.sv
// ----------------------------------------------------------------------------
// rua_pkg
// Shared constants of the rectangle union area block.
// ----------------------------------------------------------------------------
package rua_pkg;

  localparam int RuaMaxRects  = 1024;
  localparam int RuaCoordBits = 16;
  localparam int FieldW       = 16;

endpackage

// File: rtl/core/rua_ram.sv
// ----------------------------------------------------------------------------
// rua_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rua_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rua_front.sv
// ----------------------------------------------------------------------------
// rua_front
// Accept rectangle beats, mask coordinates, flag empty rectangles and hold
// them in a two-entry queue toward the sweep engine.
// ----------------------------------------------------------------------------
module rua_front
  import rua_pkg::*;
#(
  parameter int CW = 16,
  localparam int IW = 4 * CW + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [4*FieldW-1:0] s_axis_tdata,
  input  logic              s_axis_tlast,
  output logic              item_valid_o,
  input  logic              item_ready_i,
  output logic [IW-1:0]     item_o
);

  logic [CW-1:0] x1, y1, x2, y2;
  logic          usable;
  logic [IW-1:0] entry_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    fill_q;
  logic          push, pop;

  assign x1 = s_axis_tdata[CW-1:0];
  assign y1 = s_axis_tdata[FieldW+CW-1:FieldW];
  assign x2 = s_axis_tdata[2*FieldW+CW-1:2*FieldW];
  assign y2 = s_axis_tdata[3*FieldW+CW-1:3*FieldW];
  assign usable = (x1 < x2) && (y1 < y2);

  assign s_axis_tready = (fill_q != 2'd2);
  assign push = s_axis_tvalid && s_axis_tready;
  assign item_valid_o = (fill_q != 2'd0);
  assign pop = item_valid_o && item_ready_i;
  assign item_o = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= {s_axis_tlast, usable, y2, x2, y1, x1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      if (push && !pop)      fill_q <= fill_q + 2'd1;
      else if (pop && !push) fill_q <= fill_q - 2'd1;
    end
  end

endmodule

// File: rtl/core/rua_back.sv
// ----------------------------------------------------------------------------
// rua_back
// Store rectangles; on the last one build the distinct x intervals, sweep
// the distinct y levels with a cover count per interval, accumulate area.
// ----------------------------------------------------------------------------
module rua_back
  import rua_pkg::*;
#(
  parameter int MAX_RECTS = RuaMaxRects,
  parameter int CW = 16,
  localparam int IW = 4 * CW + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  output logic          item_ready_o,
  input  logic [IW-1:0] item_i,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   area_o,
  output logic          overflow_o
);

  localparam int AB   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int NB   = $clog2(MAX_RECTS + 1);
  localparam int KB   = $clog2(2 * MAX_RECTS);
  localparam int ACCW = (2 * CW > 32) ? 2 * CW : 33;

  typedef enum logic [3:0] {
    S_LOAD, S_XRD, S_XUSE, S_XEND, S_YRD, S_YUSE, S_CRD, S_CUSE, S_YEND, S_ACC, S_OUT
  } state_e;

  state_e          state_q;
  logic [AB-1:0]   i_q;
  logic [KB-1:0]   k_q, m_q;
  logic [NB-1:0]   nu_q, rect_cnt_q, nu_d;
  logic            drop_q, ovf_q, xv_q, yv_q, fnd_q, up_q;
  logic [CW-1:0]   xcur_q, ycur_q, best_q, cov_q;
  logic [2*CW-1:0] prod_q;
  logic [ACCW-1:0] acc_q;
  logic [31:0]     area_q;

  logic            pop, full, usable, last_in, last_rect, last_ivl, hit;
  logic [4*CW-1:0] rect_rd;
  logic [CW-1:0]   rx1, ry1, rx2, ry2, lo, wid;
  logic [2*CW-1:0] ivl_rd;
  logic [NB-1:0]   cnt_rd, cnt_wd;
  logic            ivl_we, cnt_we, rect_we;
  logic [CW-1:0]   ca, cb, cur, b1, b2;
  logic            cvld, f1, f2, in_x;

  assign usable  = item_i[4*CW];
  assign last_in = item_i[4*CW+1];
  assign full    = (rect_cnt_q == NB'(MAX_RECTS));
  assign item_ready_o = (state_q == S_LOAD);
  assign pop = item_valid_i && item_ready_o;
  assign nu_d = nu_q + NB'(!full && usable);

  assign {ry2, rx2, ry1, rx1} = rect_rd;
  assign lo  = ivl_rd[CW-1:0];
  assign wid = ivl_rd[2*CW-1:CW];
  assign hit = (lo >= rx1) && (lo < rx2);

  assign last_rect = ((NB'(i_q) + NB'(1)) == nu_q);
  assign last_ivl  = (KB'(k_q + KB'(1)) == m_q);

  assign rect_we = pop && !full && usable;
  assign ivl_we  = (state_q == S_XEND) && fnd_q && xv_q;
  assign cnt_we  = ivl_we || ((state_q == S_CUSE) && hit);
  assign cnt_wd  = ivl_we ? '0 : (up_q ? cnt_rd + NB'(1) : cnt_rd - NB'(1));

  assign in_x = (state_q == S_XUSE);
  assign ca   = in_x ? rx1 : ry1;
  assign cb   = in_x ? rx2 : ry2;
  assign cur  = in_x ? xcur_q : ycur_q;
  assign cvld = in_x ? xv_q : yv_q;

  always_comb begin
    b1 = best_q;
    f1 = fnd_q;
    if ((!cvld || ca > cur) && (!f1 || ca < b1)) begin
      b1 = ca;
      f1 = 1'b1;
    end
    b2 = b1;
    f2 = f1;
    if ((!cvld || cb > cur) && (!f2 || cb < b2)) begin
      b2 = cb;
      f2 = 1'b1;
    end
  end

  rua_ram #(.WIDTH(4 * CW), .DEPTH(MAX_RECTS)) u_rect_ram (
    .clk_i   (clk_i),
    .we_i    (rect_we),
    .waddr_i (nu_q[AB-1:0]),
    .wdata_i (item_i[4*CW-1:0]),
    .raddr_i (i_q),
    .rdata_o (rect_rd)
  );

  rua_ram #(.WIDTH(2 * CW), .DEPTH(2 * MAX_RECTS)) u_ivl_ram (
    .clk_i   (clk_i),
    .we_i    (ivl_we),
    .waddr_i (k_q),
    .wdata_i ({best_q - xcur_q, xcur_q}),
    .raddr_i (k_q),
    .rdata_o (ivl_rd)
  );

  rua_ram #(.WIDTH(NB), .DEPTH(2 * MAX_RECTS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (k_q),
    .wdata_i (cnt_wd),
    .raddr_i (k_q),
    .rdata_o (cnt_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      i_q        <= '0;
      k_q        <= '0;
      m_q        <= '0;
      nu_q       <= '0;
      rect_cnt_q <= '0;
      drop_q     <= 1'b0;
      ovf_q      <= 1'b0;
      xv_q       <= 1'b0;
      yv_q       <= 1'b0;
      fnd_q      <= 1'b0;
      up_q       <= 1'b0;
      xcur_q     <= '0;
      ycur_q     <= '0;
      best_q     <= '0;
      cov_q      <= '0;
      prod_q     <= '0;
      acc_q      <= '0;
      area_q     <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (pop) begin
            if (full) drop_q <= 1'b1;
            else rect_cnt_q <= rect_cnt_q + NB'(1);
            nu_q <= nu_d;
            if (last_in) begin
              ovf_q <= drop_q | full;
              xv_q  <= 1'b0;
              yv_q  <= 1'b0;
              fnd_q <= 1'b0;
              i_q   <= '0;
              k_q   <= '0;
              cov_q <= '0;
              if (nu_d == '0) begin
                area_q  <= '0;
                state_q <= S_OUT;
              end else begin
                state_q <= S_XRD;
              end
            end
          end
        end
        S_XRD: state_q <= S_XUSE;
        S_XUSE: begin
          best_q <= b2;
          fnd_q  <= f2;
          if (last_rect) begin
            state_q <= S_XEND;
          end else begin
            i_q     <= i_q + AB'(1);
            state_q <= S_XRD;
          end
        end
        S_XEND: begin
          i_q <= '0;
          if (fnd_q) begin
            if (xv_q) k_q <= k_q + KB'(1);
            xcur_q  <= best_q;
            xv_q    <= 1'b1;
            fnd_q   <= 1'b0;
            state_q <= S_XRD;
          end else begin
            m_q     <= k_q;
            state_q <= S_YRD;
          end
        end
        S_YRD: state_q <= S_YUSE;
        S_YUSE: begin
          best_q <= b2;
          fnd_q  <= f2;
          if (yv_q && (ry1 == ycur_q || ry2 == ycur_q)) begin
            up_q    <= (ry1 == ycur_q);
            k_q     <= '0;
            state_q <= S_CRD;
          end else if (last_rect) begin
            state_q <= S_YEND;
          end else begin
            i_q     <= i_q + AB'(1);
            state_q <= S_YRD;
          end
        end
        S_CRD: state_q <= S_CUSE;
        S_CUSE: begin
          if (hit && up_q && cnt_rd == '0)          cov_q <= cov_q + wid;
          if (hit && !up_q && cnt_rd == NB'(1))     cov_q <= cov_q - wid;
          if (!last_ivl) begin
            k_q     <= k_q + KB'(1);
            state_q <= S_CRD;
          end else if (last_rect) begin
            state_q <= S_YEND;
          end else begin
            i_q     <= i_q + AB'(1);
            state_q <= S_YRD;
          end
        end
        S_YEND: begin
          i_q <= '0;
          if (fnd_q) begin
            prod_q  <= (2*CW)'(cov_q) * (2*CW)'(best_q - ycur_q);
            ycur_q  <= best_q;
            yv_q    <= 1'b1;
            fnd_q   <= 1'b0;
            state_q <= yv_q ? S_ACC : S_YRD;
          end else begin
            area_q  <= (acc_q > ACCW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : acc_q[31:0];
            state_q <= S_OUT;
          end
        end
        S_ACC: begin
          acc_q   <= acc_q + ACCW'(prod_q);
          state_q <= S_YRD;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            rect_cnt_q <= '0;
            nu_q       <= '0;
            drop_q     <= 1'b0;
            acc_q      <= '0;
            state_q    <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == S_OUT);
  assign area_o        = area_q;
  assign overflow_o    = ovf_q;

  a_nu_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nu_q <= rect_cnt_q) else $error("usable count exceeds stored count");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_cnt_q <= NB'(MAX_RECTS)) else $error("store count beyond capacity");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> rect_cnt_q == '0 && acc_q == '0)
    else $error("store not cleared after result");
  a_ivl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CUSE |-> m_q != '0) else $error("cover pass with no intervals");

endmodule

// File: rtl/core/rectangle_union_area.sv
// ----------------------------------------------------------------------------
// rectangle_union_area
// Area of the union of a set of axis-aligned rectangles.
//
// Input stream: one rectangle per beat, tlast closes the set. A beat is
// taken every cycle while the set loads; a two-entry queue sits in front
// of the store, so up to two beats are taken while a result waits.
// On the closing beat the engine builds the distinct x intervals with one
// pass over the n usable rectangles per distinct x, plus one more pass
// that finds none, then sweeps each distinct y level with one pass over
// the rectangles plus an interval pass over the m intervals for every
// edge on that level. The registered reads of the rectangle and interval
// memories set the pace of every pass.
// Output stream: one beat per set, area in tdata, overflow in tuser, held
// until tready. Rectangles past MAX_RECTS are dropped and flag overflow.
// Reset empties the store and queue; tvalid is low after reset.
// ----------------------------------------------------------------------------
module rectangle_union_area
  import rua_pkg::*;
#(
  parameter int MAX_RECTS  = RuaMaxRects,
  parameter int COORD_BITS = RuaCoordBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [4*FieldW-1:0] s_axis_tdata,  // left_x, bottom_y, right_x, top_y
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,  // area
  output logic                m_axis_tuser   // overflow
);

  localparam int CW = (COORD_BITS < FieldW) ? COORD_BITS : FieldW;
  localparam int IW = 4 * CW + 2;

  logic          item_valid, item_ready;
  logic [IW-1:0] item;

  rua_front #(.CW(CW)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_o        (item)
  );

  rua_back #(.MAX_RECTS(MAX_RECTS), .CW(CW)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .area_o        (m_axis_tdata),
    .overflow_o    (m_axis_tuser)
  );

endmodule
